>>> src/salru_pkg.sv
`default_nettype none
package salru_pkg;

  localparam int TOTAL_BLOCKS = 16;
  localparam int LOG_BLOCKS   = 4;
  localparam int ADDR_BITS    = 16;
  localparam int IDX_W        = LOG_BLOCKS;
  localparam int WL_W         = 3;
  localparam int CNT_W        = 32;

  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [IDX_W:0]       ways_t;
  typedef logic [ADDR_BITS-1:0] tag_t;
  typedef logic [WL_W-1:0]      wl_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  // one classified access as it waits between front and back
  typedef struct packed {
    idx_t set;
    tag_t tag;
    wl_t  wl;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOOK = 4'b0010,
    S_SCAN = 4'b0100,
    S_FILL = 4'b1000
  } back_state_t;

endpackage
`default_nettype wire

>>> src/salru_front.sv
`default_nettype none
module salru_front (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [2:0]            cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [15:0]           block_address,
  input  wire salru_pkg::q_status_t  q_status,
  output logic                       push,
  output salru_pkg::item_t           push_item
);

  salru_pkg::wl_t   ways_log2;
  salru_pkg::wl_t   wl;
  salru_pkg::wl_t   sl;
  salru_pkg::idx_t  set_mask;
  salru_pkg::tag_t  addr;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ways_log2 <= '0;
    end else if (cfg_valid && cfg_ready) begin
      ways_log2 <= cfg_data;
    end
  end

  always_comb begin
    // saturate to a single fully associative set
    wl = (ways_log2 > salru_pkg::wl_t'(salru_pkg::LOG_BLOCKS)) ?
         salru_pkg::wl_t'(salru_pkg::LOG_BLOCKS) : ways_log2;
    sl = salru_pkg::wl_t'(salru_pkg::LOG_BLOCKS) - wl;
    addr = salru_pkg::tag_t'(block_address);
    set_mask = salru_pkg::idx_t'((salru_pkg::ways_t'(1) << sl) - salru_pkg::ways_t'(1));
    push_item.set = salru_pkg::idx_t'(addr) & set_mask;
    push_item.tag = salru_pkg::tag_t'(addr >> sl);
    push_item.wl  = wl;
  end

  assign in_ready = !q_status.full;
  assign push     = in_valid && in_ready;

endmodule
`default_nettype wire

>>> src/salru_queue.sv
`default_nettype none
module salru_queue (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire salru_pkg::item_t      push_item,
  input  wire logic                  pop,
  output salru_pkg::item_t           pop_item,
  output salru_pkg::q_status_t       q_status
);

  salru_pkg::item_t slots [2];
  logic             wptr;
  logic             rptr;
  logic [1:0]       count;
  logic             do_push;
  logic             do_pop;

  assign q_status.full  = (count == 2'd2);
  assign q_status.empty = (count == 2'd0);
  assign do_push = push && !q_status.full;
  assign do_pop  = pop && !q_status.empty;
  assign pop_item = slots[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) begin
        wptr <= !wptr;
      end
      if (do_pop) begin
        rptr <= !rptr;
      end
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule
`default_nettype wire

>>> src/salru_back.sv
`default_nettype none
module salru_back (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire salru_pkg::q_status_t  q_status,
  input  wire salru_pkg::item_t      pop_item,
  output logic                       pop,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       hit,
  output logic [3:0]                 set_index,
  output logic [3:0]                 way_used,
  output logic [31:0]                hit_total,
  output logic [31:0]                access_total
);

  localparam int N = salru_pkg::TOTAL_BLOCKS;

  salru_pkg::back_state_t state;
  salru_pkg::back_state_t state_next;

  salru_pkg::tag_t  tags   [N];
  salru_pkg::cnt_t  stamps [N];
  logic [N-1:0]     valid;
  salru_pkg::cnt_t  access_counter;
  salru_pkg::cnt_t  hit_counter;

  salru_pkg::item_t cur;
  salru_pkg::idx_t  scan_way;
  salru_pkg::idx_t  victim;
  salru_pkg::cnt_t  best_stamp;

  salru_pkg::ways_t ways;
  salru_pkg::idx_t  last_way;
  salru_pkg::idx_t  base;
  salru_pkg::idx_t  scan_e;
  salru_pkg::cnt_t  scan_stamp;
  logic [N-1:0]     match;
  logic [N-1:0]     free;
  salru_pkg::idx_t  hit_e;
  salru_pkg::idx_t  free_e;
  logic             out_free;
  logic             commit;
  logic             commit_hit;
  salru_pkg::idx_t  commit_e;
  logic             take_scan;

  always_comb begin
    ways     = salru_pkg::ways_t'(1) << cur.wl;
    last_way = salru_pkg::idx_t'(ways - salru_pkg::ways_t'(1));
    base     = salru_pkg::idx_t'(cur.set << cur.wl);
    scan_e   = base + scan_way;
    scan_stamp = stamps[scan_e];
    for (int e = 0; e < N; e++) begin
      logic in_set;
      in_set   = ((salru_pkg::idx_t'(e) >> cur.wl) == cur.set);
      match[e] = in_set && valid[e] && (tags[e] == cur.tag);
      free[e]  = in_set && !valid[e];
    end
    // lowest entry wins
    hit_e  = '0;
    free_e = '0;
    for (int e = N - 1; e >= 0; e--) begin
      if (match[e]) begin
        hit_e = salru_pkg::idx_t'(e);
      end
      if (free[e]) begin
        free_e = salru_pkg::idx_t'(e);
      end
    end
  end

  assign out_free  = !out_valid || out_ready;
  assign take_scan = (scan_way == '0) || (scan_stamp < best_stamp);

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    commit     = 1'b0;
    commit_hit = 1'b0;
    commit_e   = base + victim;
    unique case (state)
      salru_pkg::S_IDLE: begin
        if (!q_status.empty) begin
          pop        = 1'b1;
          state_next = salru_pkg::S_LOOK;
        end
      end
      salru_pkg::S_LOOK: begin
        priority if (|match) begin
          commit_hit = 1'b1;
          commit_e   = hit_e;
          commit     = out_free;
        end else if (|free) begin
          commit_e = free_e;
          commit   = out_free;
        end else if (cur.wl == '0) begin
          commit_e = base;
          commit   = out_free;
        end else begin
          state_next = salru_pkg::S_SCAN;
        end
        if (commit) begin
          state_next = salru_pkg::S_IDLE;
        end
      end
      salru_pkg::S_SCAN: begin
        if (scan_way == last_way) begin
          state_next = salru_pkg::S_FILL;
        end
      end
      salru_pkg::S_FILL: begin
        commit = out_free;
        if (commit) begin
          state_next = salru_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = salru_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= salru_pkg::S_IDLE;
      valid          <= '0;
      access_counter <= '0;
      hit_counter    <= '0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (commit) begin
        valid[commit_e] <= 1'b1;
        access_counter  <= access_counter + salru_pkg::cnt_t'(1);
        hit_counter     <= hit_counter + salru_pkg::cnt_t'(commit_hit);
        out_valid       <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= pop_item;
    end
    if (state == salru_pkg::S_LOOK) begin
      scan_way <= '0;
      victim   <= '0;
    end else if (state == salru_pkg::S_SCAN) begin
      // strict compare keeps the lower way on equal stamps
      if (take_scan) begin
        victim     <= scan_way;
        best_stamp <= scan_stamp;
      end
      scan_way <= scan_way + salru_pkg::idx_t'(1);
    end
    if (commit) begin
      stamps[commit_e] <= access_counter + salru_pkg::cnt_t'(1);
      if (!commit_hit) begin
        tags[commit_e] <= cur.tag;
      end
      hit          <= commit_hit;
      set_index    <= cur.set;
      way_used     <= commit_e - base;
      hit_total    <= hit_counter + salru_pkg::cnt_t'(commit_hit);
      access_total <= access_counter + salru_pkg::cnt_t'(1);
    end
  end

endmodule
`default_nettype wire

>>> src/set_assoc_cache_lru_lookup.sv
`default_nettype none
// channel  signals                          direction  transfer when
// cfg      cfg_valid cfg_ready cfg_data     in         cfg_valid && cfg_ready
// in       in_valid in_ready block_address  in         in_valid && in_ready
// out      out_valid out_ready hit set_index way_used hit_total access_total
//                                           out        out_valid && out_ready
//
// An access in the back end on a hit, a free-way fill or a direct-mapped miss
// pops the queue, then matches the set and writes the way. A miss on a full set
// of 2^w ways, w = min(ways_log2, 4) > 0, first scans for the oldest way, one
// stamp per cycle, then writes it. A two-entry queue lets the front keep
// accepting while the back works or a result waits on out_ready.
// Reset clears the valid bits, both totals and ways_log2; tags and stamps are not.
module set_assoc_cache_lru_lookup (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [2:0]   cfg_data,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [15:0]  block_address,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic              hit,
  output logic [3:0]        set_index,
  output logic [3:0]        way_used,
  output logic [31:0]       hit_total,
  output logic [31:0]       access_total
);

  salru_pkg::q_status_t q_status;
  salru_pkg::item_t     push_item;
  salru_pkg::item_t     pop_item;
  logic                 push;
  logic                 pop;

  salru_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .block_address (block_address),
    .q_status      (q_status),
    .push          (push),
    .push_item     (push_item)
  );

  salru_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .q_status  (q_status)
  );

  salru_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_status     (q_status),
    .pop_item     (pop_item),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .hit          (hit),
    .set_index    (set_index),
    .way_used     (way_used),
    .hit_total    (hit_total),
    .access_total (access_total)
  );

endmodule
`default_nettype wire

>>> tb/tb_set_assoc_cache_lru_lookup.sv
`default_nettype none
module tb_set_assoc_cache_lru_lookup;

  localparam int NUM_PHASES      = 11;
  localparam int PHASE_ITEMS     = 150;
  localparam int CYCLE_LIMIT     = 600000;
  localparam int DRAIN_CYCLES    = 40;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int HOLD_OFF_AFTER  = 500;
  localparam int POOL_MAX        = 40;

  typedef struct packed {
    logic            hit;
    salru_pkg::idx_t set_index;
    salru_pkg::idx_t way_used;
    salru_pkg::cnt_t hit_total;
    salru_pkg::cnt_t access_total;
  } lookup_t;

  typedef enum logic {
    ROW_CFG,
    ROW_ACCESS
  } row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [15:0] data;
    logic        typed;
    lookup_t     result;
  } stim_row_t;

  localparam lookup_t NO_RESULT = '0;
  localparam int NUM_ROWS = 30;

  // typed rows: direct-mapped after reset, conflict eviction and a hit on set 15
  localparam stim_row_t DIRECTED [NUM_ROWS] = '{
    '{ROW_ACCESS, 16'h0000, 1'b1, '{1'b0, 4'd0,  4'd0, 32'd0, 32'd1}},
    '{ROW_ACCESS, 16'h0000, 1'b1, '{1'b1, 4'd0,  4'd0, 32'd1, 32'd2}},
    '{ROW_ACCESS, 16'hFFFF, 1'b1, '{1'b0, 4'd15, 4'd0, 32'd1, 32'd3}},
    '{ROW_ACCESS, 16'h0010, 1'b1, '{1'b0, 4'd0,  4'd0, 32'd1, 32'd4}},
    '{ROW_ACCESS, 16'hFFFF, 1'b1, '{1'b1, 4'd15, 4'd0, 32'd2, 32'd5}},
    '{ROW_CFG,    16'd2,    1'b0, NO_RESULT},
    // stale contents reinterpreted under the new split
    '{ROW_ACCESS, 16'h0004, 1'b0, NO_RESULT},
    '{ROW_ACCESS, 16'h0000, 1'b0, NO_RESULT},
    '{ROW_ACCESS, 16'h0008, 1'b0, NO_RESULT},
    '{ROW_ACCESS, 16'h000C, 1'b0, NO_RESULT},
    '{ROW_ACCESS, 16'h0010, 1'b0, NO_RESULT},
    '{ROW_ACCESS, 16'h0014, 1'b0, NO_RESULT},
    '{ROW_ACCESS, 16'h0008, 1'b0, NO_RESULT},
    '{ROW_ACCESS, 16'h0018, 1'b0, NO_RESULT},
    '{ROW_CFG,    16'd4,    1'b0, NO_RESULT},
    '{ROW_ACCESS, 16'h0000, 1'b0, NO_RESULT},
    '{ROW_ACCESS, 16'hFFFF, 1'b0, NO_RESULT},
    '{ROW_ACCESS, 16'h8000, 1'b0, NO_RESULT},
    '{ROW_ACCESS, 16'h7FFF, 1'b0, NO_RESULT},
    // associativity above the block count saturates to one set
    '{ROW_CFG,    16'd7,    1'b0, NO_RESULT},
    '{ROW_ACCESS, 16'hFFFF, 1'b0, NO_RESULT},
    '{ROW_ACCESS, 16'h5555, 1'b0, NO_RESULT},
    '{ROW_ACCESS, 16'hAAAA, 1'b0, NO_RESULT},
    '{ROW_CFG,    16'd1,    1'b0, NO_RESULT},
    '{ROW_ACCESS, 16'h0001, 1'b0, NO_RESULT},
    '{ROW_ACCESS, 16'h0011, 1'b0, NO_RESULT},
    '{ROW_ACCESS, 16'h0021, 1'b0, NO_RESULT},
    '{ROW_CFG,    16'd3,    1'b0, NO_RESULT},
    '{ROW_ACCESS, 16'hFFF7, 1'b0, NO_RESULT},
    '{ROW_ACCESS, 16'h0007, 1'b0, NO_RESULT}
  };

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [15:0] block_address;
  logic        out_valid;
  logic        out_ready;
  logic        hit;
  logic [3:0]  set_index;
  logic [3:0]  way_used;
  logic [31:0] hit_total;
  logic [31:0] access_total;

  // shadow tag store
  salru_pkg::tag_t tag_mem   [salru_pkg::TOTAL_BLOCKS];
  logic            valid_mem [salru_pkg::TOTAL_BLOCKS];
  salru_pkg::cnt_t stamp_mem [salru_pkg::TOTAL_BLOCKS];
  salru_pkg::cnt_t access_count;
  salru_pkg::cnt_t hit_count;
  salru_pkg::wl_t  ways_log2_cfg;

  lookup_t pending_lookups[$];
  int      fault_count;
  int      results_seen;
  int      cycle_count;

  set_assoc_cache_lru_lookup dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .block_address(block_address),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .hit          (hit),
    .set_index    (set_index),
    .way_used     (way_used),
    .hit_total    (hit_total),
    .access_total (access_total)
  );

  function automatic lookup_t predict_lookup(input logic [15:0] addr);
    int unsigned     wl;
    int unsigned     sl;
    int unsigned     ways;
    int unsigned     set_no;
    int unsigned     base;
    int unsigned     way;
    int unsigned     e;
    salru_pkg::tag_t tag;
    logic            found;
    logic            free_found;
    lookup_t         r;
    wl = (ways_log2_cfg > salru_pkg::LOG_BLOCKS) ? salru_pkg::LOG_BLOCKS : ways_log2_cfg;
    sl = salru_pkg::LOG_BLOCKS - wl;
    ways = 1 << wl;
    set_no = addr & ((1 << sl) - 1);
    tag = salru_pkg::tag_t'(addr >> sl);
    base = set_no * ways;
    way = 0;
    found = 1'b0;
    free_found = 1'b0;
    // check every way for a hit before choosing a fill
    for (int v = 0; v < ways; v++) begin
      e = (base + v) % salru_pkg::TOTAL_BLOCKS;
      if (!found && valid_mem[e] && tag_mem[e] == tag) begin
        found = 1'b1;
        way = v;
      end
    end
    if (!found) begin
      for (int v = 0; v < ways; v++) begin
        e = (base + v) % salru_pkg::TOTAL_BLOCKS;
        if (!free_found && !valid_mem[e]) begin
          free_found = 1'b1;
          way = v;
        end
      end
      // lowest way with the strictly smallest stamp
      if (!free_found) begin
        way = 0;
        for (int v = 1; v < ways; v++) begin
          e = (base + v) % salru_pkg::TOTAL_BLOCKS;
          if (stamp_mem[e] < stamp_mem[(base + way) % salru_pkg::TOTAL_BLOCKS]) way = v;
        end
      end
    end
    access_count = access_count + 1;
    e = (base + way) % salru_pkg::TOTAL_BLOCKS;
    valid_mem[e] = 1'b1;
    stamp_mem[e] = access_count;
    if (found) hit_count = hit_count + 1;
    else tag_mem[e] = tag;
    r.hit = found;
    r.set_index = salru_pkg::idx_t'(set_no);
    r.way_used = salru_pkg::idx_t'(way);
    r.hit_total = hit_count;
    r.access_total = access_count;
    return r;
  endfunction

  task automatic write_ways(input salru_pkg::wl_t value);
    in_valid <= 1'b0;
    // write only with the block drained
    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    ways_log2_cfg = value;
  endtask

  task automatic send_access(input logic [15:0] addr, input logic typed,
                             input lookup_t typed_result);
    lookup_t predicted;
    in_valid <= 1'b1;
    block_address <= addr;
    do @(posedge clk); while (!in_ready);
    predicted = predict_lookup(addr);
    pending_lookups.push_back(typed ? typed_result : predicted);
  endtask

  task automatic pause_input(input logic no_gap);
    int unsigned roll;
    int unsigned gap;
    roll = $urandom_range(0, 99);
    gap = 0;
    if (!no_gap) begin
      if (roll >= 95) gap = $urandom_range(10, 40);
      else if (roll >= 60) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("set_assoc_cache_lru_lookup test failed");
    $finish;
  end

  initial begin : drive_ready
    int unsigned roll;
    int          stall_left;
    int          free_left;
    int          hold_left;
    logic        pressure_done;
    stall_left = 0;
    free_left = 0;
    hold_left = 0;
    pressure_done = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!pressure_done && results_seen >= HOLD_OFF_AFTER) begin
        // hold off long enough for the queue to fill and stall the input
        pressure_done = 1'b1;
        hold_left = HOLD_OFF_CYCLES - 1;
        out_ready <= 1'b0;
      end else if (free_left > 0) begin
        free_left--;
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
          free_left = $urandom_range(40, 150);
          out_ready <= 1'b1;
        end else if (roll < 70) begin
          out_ready <= 1'b1;
        end else if (roll < 96) begin
          stall_left = $urandom_range(0, 2);
          out_ready <= 1'b0;
        end else begin
          stall_left = $urandom_range(8, 40);
          out_ready <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_results
    lookup_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_lookups.size() == 0) begin
        $error("result transfer with no pending lookup: set_index %0d way_used %0d",
               set_index, way_used);
        fault_count++;
      end else begin
        want = pending_lookups.pop_front();
        if (hit !== want.hit) begin
          $error("hit: expected %0d, actual %0d", want.hit, hit);
          fault_count++;
        end
        if (set_index !== want.set_index) begin
          $error("set_index: expected %0d, actual %0d", want.set_index, set_index);
          fault_count++;
        end
        if (way_used !== want.way_used) begin
          $error("way_used: expected %0d, actual %0d", want.way_used, way_used);
          fault_count++;
        end
        if (hit_total !== want.hit_total) begin
          $error("hit_total: expected %0d, actual %0d", want.hit_total, hit_total);
          fault_count++;
        end
        if (access_total !== want.access_total) begin
          $error("access_total: expected %0d, actual %0d", want.access_total,
                 access_total);
          fault_count++;
        end
      end
    end
  end

  initial begin : run_stimulus
    logic [15:0]    addr_pool [POOL_MAX];
    int unsigned    pool_size;
    logic [15:0]    addr;
    logic           no_gap;
    salru_pkg::wl_t phase_ways;
    fault_count = 0;
    results_seen = 0;
    for (int i = 0; i < salru_pkg::TOTAL_BLOCKS; i++) begin
      tag_mem[i] = '0;
      valid_mem[i] = 1'b0;
      stamp_mem[i] = '0;
    end
    access_count = '0;
    hit_count = '0;
    ways_log2_cfg = '0;
    rst <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    block_address <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == ROW_CFG) begin
        write_ways(salru_pkg::wl_t'(DIRECTED[i].data));
      end else begin
        send_access(DIRECTED[i].data, DIRECTED[i].typed, DIRECTED[i].result);
        pause_input(1'b0);
      end
    end

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase == 0) phase_ways = '0;
      else if (phase == 1) phase_ways = salru_pkg::wl_t'(salru_pkg::LOG_BLOCKS);
      else if (phase == 2) phase_ways = '1;
      else phase_ways = salru_pkg::wl_t'($urandom_range(0, 7));
      write_ways(phase_ways);
      no_gap = (phase % 4 == 3);
      // draw most accesses from a small working set so that hits and evictions occur
      pool_size = $urandom_range(4, POOL_MAX);
      for (int i = 0; i < pool_size; i++) addr_pool[i] = 16'($urandom_range(0, 65535));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 99) < 85) addr = addr_pool[$urandom_range(0, pool_size - 1)];
        else addr = 16'($urandom_range(0, 65535));
        send_access(addr, 1'b0, NO_RESULT);
        pause_input(no_gap);
      end
    end
    in_valid <= 1'b0;

    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fault_count == 0) begin
      $display("set_assoc_cache_lru_lookup test passed");
    end else begin
      $display("set_assoc_cache_lru_lookup test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
